FILE: rtl/c2rs_pkg.sv
// Shared types, codes and helpers for the CIGAR to reference segment block.
package c2rs_pkg;

  // Width of reference positions and lengths held internally (16..64)
  localparam int unsigned POS_WIDTH = 32;

  // Depth of the result bundle queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Most results one operation can cause
  localparam int unsigned MAX_RES = 3;

  // CIGAR operation codes
  localparam logic [3:0] OP_MATCH = 4'd0;
  localparam logic [3:0] OP_INS   = 4'd1;
  localparam logic [3:0] OP_DEL   = 4'd2;
  localparam logic [3:0] OP_SKIP  = 4'd3;
  localparam logic [3:0] OP_SOFT  = 4'd4;

  typedef enum logic [1:0] {
    KIND_MATCH  = 2'd0,
    KIND_INTRON = 2'd1,
    KIND_OK     = 2'd2,
    KIND_ERR    = 2'd3
  } kind_e;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] start;
    logic [31:0] length;
  } result_t;

  // All results caused by one operation, oldest in slot 0
  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

  // Low 32 bits of a position, zero extended when positions are narrower
  function automatic logic [31:0] to_out32(pos_t p);
    logic [63:0] wide;
    wide = 64'(p);
    return wide[31:0];
  endfunction

endpackage

FILE: rtl/cigar_to_reference_segments_top.sv
// Top level of the CIGAR operation to reference segment converter.
// One CIGAR operation is taken per clock while full is low; the front end
// updates the read state in that cycle and writes all results the operation
// causes (none to three) as one bundle into a four-deep queue. The back end
// hands out one result beat per clock while pop is high; with the output side
// idle the first result of an operation reaches the result ports through the
// queue entry and then the back end's current-bundle register. Input rate
// stays at one operation per cycle as long as the output drains about one
// result per operation, the queue depth setting how long an end-of-read burst
// can be absorbed.
module cigar_to_reference_segments_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  op_code_i,
  input  logic [27:0] op_length_i,
  input  logic [31:0] read_left_i,
  input  logic        last_op_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [31:0] seg_start_o,
  output logic [31:0] seg_length_o,
  output logic        last_result_o
);

  logic              accept;
  logic              f_push;
  c2rs_pkg::bundle_t f_bundle, q_data;
  logic              q_empty, q_pop;

  assign accept = push && !full;

  c2rs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_code_i   (op_code_i),
    .op_length_i (op_length_i),
    .read_left_i (read_left_i),
    .last_op_i   (last_op_i),
    .push_o      (f_push),
    .bundle_o    (f_bundle)
  );

  c2rs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_bundle),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  c2rs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_data_i      (q_data),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .result_kind_o (result_kind_o),
    .seg_start_o   (seg_start_o),
    .seg_length_o  (seg_length_o),
    .last_result_o (last_result_o)
  );

endmodule

FILE: rtl/c2rs_front.sv
// Front end: per-read state, classifies each CIGAR operation into a result bundle.
module c2rs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [3:0]          op_code_i,
  input  logic [27:0]         op_length_i,
  input  logic [31:0]         read_left_i,
  input  logic                last_op_i,
  output logic                push_o,
  output c2rs_pkg::bundle_t   bundle_o
);

  logic               held_valid_q, held_valid_d;
  logic               held_intron_q, held_intron_d;
  c2rs_pkg::pos_t     held_start_q, held_start_d;
  c2rs_pkg::pos_t     held_len_q, held_len_d;
  c2rs_pkg::pos_t     ref_pos_q, ref_pos_d;
  c2rs_pkg::pos_t     pend_del_q, pend_del_d;
  logic               prev_match_q, prev_match_d;
  logic               need_match_q, need_match_d;
  logic               dropping_q, dropping_d;
  logic               inside_q, inside_d;

  // Next state and results for the operation on the inputs
  always_comb begin
    logic               err;
    logic [1:0]         n;
    c2rs_pkg::pos_t     len;
    c2rs_pkg::bundle_t  b;

    held_valid_d  = held_valid_q;
    held_intron_d = held_intron_q;
    held_start_d  = held_start_q;
    held_len_d    = held_len_q;
    ref_pos_d     = ref_pos_q;
    pend_del_d    = pend_del_q;
    prev_match_d  = prev_match_q;
    need_match_d  = need_match_q;
    dropping_d    = dropping_q;
    inside_d      = inside_q;
    err           = 1'b0;
    n             = 2'd0;
    len           = c2rs_pkg::POS_WIDTH'(op_length_i);
    b             = '0;

    if (dropping_q) begin
      // rest of a failed read: swallow until its last operation
      if (last_op_i) begin
        dropping_d = 1'b0;
        inside_d   = 1'b0;
      end
    end else begin
      // first operation of a read
      if (!inside_q) begin
        inside_d     = 1'b1;
        ref_pos_d    = c2rs_pkg::POS_WIDTH'(read_left_i);
        held_valid_d = 1'b0;
        prev_match_d = 1'b0;
        need_match_d = 1'b0;
        pend_del_d   = '0;
      end

      if (need_match_d && op_code_i != c2rs_pkg::OP_MATCH) begin
        err = 1'b1;
      end else begin
        if (need_match_d) begin
          held_len_d   = held_len_d + pend_del_d;
          pend_del_d   = '0;
          need_match_d = 1'b0;
        end
        unique case (op_code_i) inside
          c2rs_pkg::OP_MATCH, c2rs_pkg::OP_SKIP: begin
            if (held_valid_d) begin
              b.res[n].kind   = held_intron_d ? c2rs_pkg::KIND_INTRON : c2rs_pkg::KIND_MATCH;
              b.res[n].start  = c2rs_pkg::to_out32(held_start_d);
              b.res[n].length = c2rs_pkg::to_out32(held_len_d);
              n = n + 2'd1;
            end
            held_valid_d  = 1'b1;
            held_intron_d = (op_code_i == c2rs_pkg::OP_SKIP);
            held_start_d  = ref_pos_d;
            held_len_d    = len;
            ref_pos_d     = ref_pos_d + len;
            prev_match_d  = (op_code_i == c2rs_pkg::OP_MATCH);
          end
          c2rs_pkg::OP_INS, c2rs_pkg::OP_DEL: begin
            if (!prev_match_d || last_op_i || !held_valid_d) begin
              err = 1'b1;
            end else begin
              if (op_code_i == c2rs_pkg::OP_DEL) begin
                pend_del_d = len;
                ref_pos_d  = ref_pos_d + len;
              end else begin
                pend_del_d = '0;
              end
              need_match_d = 1'b1;
              prev_match_d = 1'b0;
            end
          end
          c2rs_pkg::OP_SOFT: begin
            prev_match_d = 1'b0;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end

      // end of read or error: flush the held segment, then the end marker
      if (err || last_op_i) begin
        if (held_valid_d) begin
          b.res[n].kind   = held_intron_d ? c2rs_pkg::KIND_INTRON : c2rs_pkg::KIND_MATCH;
          b.res[n].start  = c2rs_pkg::to_out32(held_start_d);
          b.res[n].length = c2rs_pkg::to_out32(held_len_d);
          n = n + 2'd1;
        end
        held_valid_d    = 1'b0;
        b.res[n].kind   = err ? c2rs_pkg::KIND_ERR : c2rs_pkg::KIND_OK;
        b.res[n].start  = '0;
        b.res[n].length = '0;
        n = n + 2'd1;
        prev_match_d    = 1'b0;
        if (err) begin
          need_match_d = 1'b0;
          pend_del_d   = '0;
        end
        if (last_op_i) begin
          inside_d = 1'b0;
        end else begin
          dropping_d = 1'b1;
        end
      end
    end

    b.cnt    = n;
    bundle_o = b;
    push_o   = accept_i && (n != 2'd0);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q  <= 1'b0;
      held_intron_q <= 1'b0;
      prev_match_q  <= 1'b0;
      need_match_q  <= 1'b0;
      dropping_q    <= 1'b0;
      inside_q      <= 1'b0;
      held_start_q  <= '0;
      held_len_q    <= '0;
      ref_pos_q     <= '0;
      pend_del_q    <= '0;
    end else if (accept_i) begin
      held_valid_q  <= held_valid_d;
      held_intron_q <= held_intron_d;
      prev_match_q  <= prev_match_d;
      need_match_q  <= need_match_d;
      dropping_q    <= dropping_d;
      inside_q      <= inside_d;
      held_start_q  <= held_start_d;
      held_len_q    <= held_len_d;
      ref_pos_q     <= ref_pos_d;
      pend_del_q    <= pend_del_d;
    end
  end

  // Dropping only happens inside a read
  a_drop_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropping_q |-> inside_q)
    else $error("dropping outside a read");

  // A waiting insertion or deletion always has a held segment to extend
  a_need_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_match_q |-> (held_valid_q && inside_q && !dropping_q))
    else $error("pending indel without held segment");

endmodule

FILE: rtl/c2rs_queue.sv
// Short queue of result bundles between the front and back ends.
module c2rs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  c2rs_pkg::bundle_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output c2rs_pkg::bundle_t rdata_o,
  output logic              empty_o
);

  c2rs_pkg::bundle_t                 entry_q [c2rs_pkg::QDEPTH];
  logic [c2rs_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
  logic [c2rs_pkg::QCNT_W-1:0]       count_q;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == c2rs_pkg::QCNT_W'(c2rs_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entry_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == c2rs_pkg::QPTR_W'(c2rs_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == c2rs_pkg::QPTR_W'(c2rs_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + c2rs_pkg::QCNT_W'(do_push) - c2rs_pkg::QCNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bundle pushed into full queue");

endmodule

FILE: rtl/c2rs_back.sv
// Back end: unpacks result bundles and presents one result beat at a time.
module c2rs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c2rs_pkg::bundle_t q_data_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        result_kind_o,
  output logic [31:0]       seg_start_o,
  output logic [31:0]       seg_length_o,
  output logic              last_result_o
);

  c2rs_pkg::bundle_t cur_q;
  logic              cur_valid_q;
  logic [1:0]        idx_q;
  logic              at_last, free;

  assign at_last = (idx_q == cur_q.cnt - 2'd1);
  assign free    = !cur_valid_q || (pop && at_last);
  assign q_pop_o = free && !q_empty_i;

  assign empty         = !cur_valid_q;
  assign result_kind_o = cur_q.res[idx_q].kind;
  assign seg_start_o   = cur_q.res[idx_q].start;
  assign seg_length_o  = cur_q.res[idx_q].length;
  assign last_result_o = at_last;

  // Current bundle
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // Beat index within the bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (free) begin
      cur_valid_q <= !q_empty_i;
      idx_q       <= '0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.cnt != 2'd0 && idx_q < cur_q.cnt))
    else $error("beat index outside bundle");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && !pop) |=> (cur_valid_q && $stable(idx_q)))
    else $error("result changed while stalled");

endmodule
